FILE: sv/radix_string_to_u128_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix string parser core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIX_STRING_TO_U128_PARSER_CORE_ASSERT_SVH
`define RADIX_STRING_TO_U128_PARSER_CORE_ASSERT_SVH

// Same-cycle implication
`define RSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the radix string to u128 parser.
// ----------------------------------------------------------------------------
package rsp_pkg;

	// Field widths
	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 6;
	localparam int ACC_W    = 128;
	localparam int HALF_W   = 64;
	localparam int PROD_W   = ACC_W + RADIX_W;
	localparam int OUTCNT_W = 16;
	localparam int STAT_W   = 2;

	// Digit counter, saturating
	localparam int COUNT_BITS = 16;
	localparam int CNTX_W     = (COUNT_BITS > OUTCNT_W) ? COUNT_BITS : OUTCNT_W;

	// Radix limits and reset value
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(10);

	// Character constants
	localparam logic [CHAR_W-1:0] CH_0 = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CH_9 = CHAR_W'(8'h39);
	localparam logic [CHAR_W-1:0] CH_UA = CHAR_W'(8'h41);
	localparam logic [CHAR_W-1:0] CH_UZ = CHAR_W'(8'h5A);
	localparam logic [CHAR_W-1:0] CH_LA = CHAR_W'(8'h61);
	localparam logic [CHAR_W-1:0] CH_LZ = CHAR_W'(8'h7A);
	localparam logic [RADIX_W-1:0] LETTER_BASE = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] NOT_DIGIT   = RADIX_W'(36);

	// Queue sizing
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = RADIX_W;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP = CFG_IDX_W'(1);

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_NONE  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	// Per-character operation decided by the front end
	typedef enum logic {
		OP_SKIP  = 1'b0,
		OP_DIGIT = 1'b1
	} op_t;

	// One queued character
	typedef struct packed {
		op_t                op;
		logic [RADIX_W-1:0] digit;
		logic [RADIX_W-1:0] radix;
		logic               last;
	} entry_t;

	// Queue occupancy status
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	// Map a character to its digit value, NOT_DIGIT when not alphanumeric
	function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [RADIX_W-1:0] d;
		d = NOT_DIGIT;
		if (c >= CH_0 && c <= CH_9)
			d = RADIX_W'(c - CH_0);
		else if (c >= CH_UA && c <= CH_UZ)
			d = RADIX_W'(c - CH_UA) + LETTER_BASE;
		else if (c >= CH_LA && c <= CH_LZ)
			d = RADIX_W'(c - CH_LA) + LETTER_BASE;
		return d;
	endfunction

endpackage

FILE: sv/rsp_chr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_chr_if
// Character channel: one string byte per beat.
// ----------------------------------------------------------------------------
interface rsp_chr_if;
	logic                        valid;
	logic                        ready;
	logic [rsp_pkg::CHAR_W-1:0]  char_code;
	logic                        end_of_string;

	modport source (output valid, output char_code, output end_of_string, input ready);
	modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

FILE: sv/rsp_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_res_if
// Result channel: one parsed value per beat.
// ----------------------------------------------------------------------------
interface rsp_res_if;
	logic                          valid;
	logic                          ready;
	logic [rsp_pkg::HALF_W-1:0]    value_low;
	logic [rsp_pkg::HALF_W-1:0]    value_high;
	logic [rsp_pkg::OUTCNT_W-1:0]  chars_consumed;
	logic [rsp_pkg::STAT_W-1:0]    status;

	modport source (output valid, output value_low, output value_high,
		output chars_consumed, output status, input ready);
	modport sink (input valid, input value_low, input value_high,
		input chars_consumed, input status, output ready);
endinterface

FILE: sv/rsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_front
// Accepts characters, decodes digits against the radix and tracks the stop.
// ----------------------------------------------------------------------------
module rsp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	rsp_chr_if.sink                      chr,
	input  logic [rsp_pkg::RADIX_W-1:0]  radix,
	input  rsp_pkg::qstat_t              qstat,
	output logic                         push,
	output rsp_pkg::entry_t              push_data
);

	logic                        stop_q;
	logic [rsp_pkg::RADIX_W-1:0] radix_eff;
	logic [rsp_pkg::RADIX_W-1:0] dig;
	logic                        is_dig;

	// Clamp the radix into 2..36
	always_comb begin
		radix_eff = radix;
		if (radix < rsp_pkg::RADIX_MIN)
			radix_eff = rsp_pkg::RADIX_MIN;
		else if (radix > rsp_pkg::RADIX_MAX)
			radix_eff = rsp_pkg::RADIX_MAX;
	end

	// Classify the beat
	assign dig    = rsp_pkg::digit_of(chr.char_code);
	assign is_dig = !stop_q && (dig < radix_eff);

	assign chr.ready = !qstat.full;
	assign push      = chr.valid && chr.ready;

	always_comb begin
		push_data.op    = is_dig ? rsp_pkg::OP_DIGIT : rsp_pkg::OP_SKIP;
		push_data.digit = dig;
		push_data.radix = radix_eff;
		push_data.last  = chr.end_of_string;
	end

	// Scan stop flag: set by the first non-digit, cleared at string end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
		end else if (push) begin
			if (chr.end_of_string)
				stop_q <= 1'b0;
			else if (!is_dig)
				stop_q <= 1'b1;
		end
	end

endmodule

FILE: sv/rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_queue
// Short FIFO of decoded characters between front and back end.
// ----------------------------------------------------------------------------
module rsp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rsp_pkg::entry_t  push_data,
	input  logic             pop,
	output rsp_pkg::entry_t  head,
	output rsp_pkg::qstat_t  qstat
);

	rsp_pkg::entry_t             mem_q [rsp_pkg::QDEPTH];
	logic [rsp_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [rsp_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [rsp_pkg::QCNT_W-1:0]  cnt_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.count = cnt_q;
	assign qstat.full  = (cnt_q == rsp_pkg::QCNT_W'(rsp_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/rsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_back
// Multiply-add accumulator, digit counter and result register.
// ----------------------------------------------------------------------------
module rsp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rsp_pkg::entry_t  head,
	input  rsp_pkg::qstat_t  qstat,
	input  logic             clamp,
	output logic             pop,
	rsp_res_if.source        res
);

	logic [rsp_pkg::ACC_W-1:0]      acc_q, acc_n;
	logic                           ovf_q, ovf_n;
	logic [rsp_pkg::COUNT_BITS-1:0] cnt_q, cnt_n;
	logic [rsp_pkg::PROD_W-1:0]     prod;
	logic [rsp_pkg::CNTX_W-1:0]     cnt_x;
	logic                           out_vld_q;
	logic [rsp_pkg::ACC_W-1:0]      val_n;
	logic [rsp_pkg::OUTCNT_W-1:0]   ocnt_n;
	rsp_pkg::status_t               stat_n;

	// A non-final beat never needs the result slot
	assign pop = !qstat.empty && (!head.last || !out_vld_q || res.ready);

	// accum * radix + digit, overflow when anything lands above bit 127
	assign prod = rsp_pkg::PROD_W'(acc_q) * rsp_pkg::PROD_W'(head.radix)
		+ rsp_pkg::PROD_W'(head.digit);

	always_comb begin
		acc_n = acc_q;
		ovf_n = ovf_q;
		cnt_n = cnt_q;
		if (head.op == rsp_pkg::OP_DIGIT) begin
			if (!ovf_q) begin
				if (prod[rsp_pkg::PROD_W-1:rsp_pkg::ACC_W] == '0)
					acc_n = prod[rsp_pkg::ACC_W-1:0];
				else
					ovf_n = 1'b1;
			end
			if (cnt_q != '1)
				cnt_n = cnt_q + 1'b1;
		end
	end

	// Result formatting
	assign cnt_x  = rsp_pkg::CNTX_W'(cnt_n);
	assign ocnt_n = (cnt_x > rsp_pkg::CNTX_W'({rsp_pkg::OUTCNT_W{1'b1}}))
		? {rsp_pkg::OUTCNT_W{1'b1}} : cnt_x[rsp_pkg::OUTCNT_W-1:0];

	always_comb begin
		if (cnt_n == '0) begin
			stat_n = rsp_pkg::STAT_NONE;
			val_n  = '0;
		end else if (ovf_n) begin
			stat_n = rsp_pkg::STAT_RANGE;
			val_n  = clamp ? '1 : '0;
		end else begin
			stat_n = rsp_pkg::STAT_OK;
			val_n  = acc_n;
		end
	end

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_n;
				ovf_q <= ovf_n;
				cnt_q <= cnt_n;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (pop && head.last)
			out_vld_q <= 1'b1;
		else if (res.ready)
			out_vld_q <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			res.value_low      <= val_n[rsp_pkg::HALF_W-1:0];
			res.value_high     <= val_n[rsp_pkg::ACC_W-1:rsp_pkg::HALF_W];
			res.chars_consumed <= ocnt_n;
			res.status         <= stat_n;
		end
	end

	assign res.valid = out_vld_q;

endmodule

FILE: sv/radix_string_to_u128_parser_core.sv
`timescale 1ns / 1ps
// Result path: an end_of_string beat is written into the queue when accepted; the
//   combinational 128x6 multiply-add and the result register act on it when popped.
// Throughput: one character per cycle while the queue is not full.
// Reset (arst_n low): radix 10, clamp off, queue empty, accumulator and count zero.
// ----------------------------------------------------------------------------
// radix_string_to_u128_parser_core
// Top level: config registers, decode front end, queue and accumulate back end.
// ----------------------------------------------------------------------------
`include "radix_string_to_u128_parser_core_assert.svh"

module radix_string_to_u128_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	rsp_chr_if.sink                        chr,
	rsp_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rsp_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

	logic [rsp_pkg::RADIX_W-1:0] radix_q;
	logic                        clamp_q;
	logic                        push;
	logic                        pop;
	rsp_pkg::entry_t             push_data;
	rsp_pkg::entry_t             head;
	rsp_pkg::qstat_t             qstat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rsp_pkg::RADIX_RST;
			clamp_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rsp_pkg::REG_RADIX: radix_q <= cfg_wdata;
				rsp_pkg::REG_CLAMP: clamp_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	rsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr       (chr),
		.radix     (radix_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	rsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	rsp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.clamp  (clamp_q),
		.pop    (pop),
		.res    (res)
	);

	// Checks
	`RSP_ASSERT_NOW(a_q_bound, 1'b1, qstat.count <= rsp_pkg::QCNT_W'(rsp_pkg::QDEPTH), "queue overfilled")
	`RSP_ASSERT_NOW(a_ok_count, res.valid && res.status == rsp_pkg::STAT_OK, res.chars_consumed != '0, "ok result with no digits")
	`RSP_ASSERT_NOW(a_none_zero, res.valid && res.status == rsp_pkg::STAT_NONE, res.value_low == '0 && res.value_high == '0 && res.chars_consumed == '0, "empty result not zero")
	`RSP_ASSERT_NXT(a_push_fill, push && !pop && !qstat.full, !qstat.empty, "pushed beat lost")

endmodule
